@@ rtl/core/burst_pushpull_dead_time_gen_macros.svh @@
// assertion macros shared by the burst push-pull generator modules
`ifndef BURST_PUSHPULL_DEAD_TIME_GEN_MACROS_SVH
`define BURST_PUSHPULL_DEAD_TIME_GEN_MACROS_SVH

// same-cycle implication, checked on aclk, off while aresetn is low
`define BPPG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bppg assertion failed");

// next-cycle implication, checked on aclk, off while aresetn is low
`define BPPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bppg assertion failed");

`endif

@@ rtl/core/bppg_pkg.sv @@
// types, widths and register codes of the burst push-pull generator
package bppg_pkg;

    // counter widths
    localparam int FRAME_COUNT_WIDTH   = 20;
    localparam int CARRIER_COUNT_WIDTH = 16;

    // register widths
    localparam int TPU_W      = 8;
    localparam int FPERIOD_W  = 20;
    localparam int BURST_W    = 20;
    localparam int CPERIOD_W  = 16;
    localparam int HALF_W     = 16;
    localparam int DEAD_W     = 15;
    localparam int TSTART_W   = 20;
    localparam int TLEN_W     = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 4;

    // compare widths: wide enough for every operand plus a carry bit (two spare bits for the carrier)
    localparam int FRAME_CMP_W =
        ((FRAME_COUNT_WIDTH > FPERIOD_W) ? FRAME_COUNT_WIDTH : FPERIOD_W) + 1;
    localparam int CARRIER_CMP_W =
        ((CARRIER_COUNT_WIDTH > CPERIOD_W) ? CARRIER_COUNT_WIDTH : CPERIOD_W) + 2;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TPU     = 4'd0,
        REG_FPERIOD = 4'd1,
        REG_BURST   = 4'd2,
        REG_CPERIOD = 4'd3,
        REG_HALF    = 4'd4,
        REG_DEAD    = 4'd5,
        REG_TSTART  = 4'd6,
        REG_TLEN    = 4'd7
    } cfg_addr_t;

    // reset values
    localparam logic [TPU_W-1:0]     RST_TPU     = 8'd16;
    localparam logic [FPERIOD_W-1:0] RST_FPERIOD = 20'd1000000;
    localparam logic [BURST_W-1:0]   RST_BURST   = 20'd200000;
    localparam logic [CPERIOD_W-1:0] RST_CPERIOD = 16'd1000;
    localparam logic [HALF_W-1:0]    RST_HALF    = 16'd500;
    localparam logic [DEAD_W-1:0]    RST_DEAD    = 15'd10;
    localparam logic [TSTART_W-1:0]  RST_TSTART  = 20'd50000;
    localparam logic [TLEN_W-1:0]    RST_TLEN    = 20'd5000;

    typedef struct packed {
        logic [TPU_W-1:0]     ticks_per_microsecond;
        logic [FPERIOD_W-1:0] frame_period;
        logic [BURST_W-1:0]   burst_length;
        logic [CPERIOD_W-1:0] carrier_period;
        logic [HALF_W-1:0]    half_point;
        logic [DEAD_W-1:0]    dead_time;
        logic [TSTART_W-1:0]  trigger_start;
        logic [TLEN_W-1:0]    trigger_length;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_COUNT_WIDTH-1:0]   frame_microseconds;
        logic [CARRIER_COUNT_WIDTH-1:0] carrier_microseconds;
        logic                           frame_wrap;
    } count_t;

    typedef struct packed {
        logic frame_wrap;
        logic trigger_pulse;
        logic drive_b;
        logic drive_a;
    } result_t;

endpackage

@@ rtl/core/bppg_cfg_regs.sv @@
// configuration register file of the burst push-pull generator
module bppg_cfg_regs import bppg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode the write, mask the data to the register width
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            unique case (cfg_addr)
                REG_TPU:     cfg_next.ticks_per_microsecond = cfg_wdata[TPU_W-1:0];
                REG_FPERIOD: cfg_next.frame_period          = cfg_wdata[FPERIOD_W-1:0];
                REG_BURST:   cfg_next.burst_length          = cfg_wdata[BURST_W-1:0];
                REG_CPERIOD: cfg_next.carrier_period        = cfg_wdata[CPERIOD_W-1:0];
                REG_HALF:    cfg_next.half_point            = cfg_wdata[HALF_W-1:0];
                REG_DEAD:    cfg_next.dead_time             = cfg_wdata[DEAD_W-1:0];
                REG_TSTART:  cfg_next.trigger_start         = cfg_wdata[TSTART_W-1:0];
                REG_TLEN:    cfg_next.trigger_length        = cfg_wdata[TLEN_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_microsecond <= RST_TPU;
            cfg_reg.frame_period          <= RST_FPERIOD;
            cfg_reg.burst_length          <= RST_BURST;
            cfg_reg.carrier_period        <= RST_CPERIOD;
            cfg_reg.half_point            <= RST_HALF;
            cfg_reg.dead_time             <= RST_DEAD;
            cfg_reg.trigger_start         <= RST_TSTART;
            cfg_reg.trigger_length        <= RST_TLEN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/bppg_timebase.sv @@
// prescaler, frame counter and carrier counter of the burst push-pull generator
module bppg_timebase import bppg_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   step,
    input  logic   tick,
    input  cfg_t   cfg,
    output count_t cnt
);

    `include "burst_pushpull_dead_time_gen_macros.svh"

    logic [TPU_W-1:0]               pre_reg, pre_next;
    logic [FRAME_COUNT_WIDTH-1:0]   frame_reg, frame_next;
    logic [CARRIER_COUNT_WIDTH-1:0] carrier_reg, carrier_next;
    logic                           wrap_reg, wrap_next;

    logic [TPU_W:0]               pre_inc;
    logic [FRAME_COUNT_WIDTH:0]   frame_inc;
    logic [CARRIER_COUNT_WIDTH:0] carrier_inc;
    logic                         us_done, frame_done, carrier_done;

    // increments with a carry bit and wrap decisions
    always_comb begin
        pre_inc     = {1'b0, pre_reg} + 1'b1;
        frame_inc   = {1'b0, frame_reg} + 1'b1;
        carrier_inc = {1'b0, carrier_reg} + 1'b1;
        us_done     = (pre_inc >= {1'b0, cfg.ticks_per_microsecond}) || pre_inc[TPU_W];
        frame_done  = (FRAME_CMP_W'(frame_inc) >= FRAME_CMP_W'(cfg.frame_period))
                      || frame_inc[FRAME_COUNT_WIDTH];
        carrier_done = (CARRIER_CMP_W'(carrier_inc) >= CARRIER_CMP_W'(cfg.carrier_period))
                       || carrier_inc[CARRIER_COUNT_WIDTH];
    end

    // counter update for one accepted beat
    always_comb begin
        pre_next     = pre_reg;
        frame_next   = frame_reg;
        carrier_next = carrier_reg;
        wrap_next    = wrap_reg;
        if (step) begin
            wrap_next = 1'b0;
            if (tick) begin
                if (us_done) begin
                    pre_next = '0;
                    if (frame_done) begin
                        frame_next   = '0;
                        carrier_next = '0;
                        wrap_next    = 1'b1;
                    end else begin
                        frame_next   = frame_inc[FRAME_COUNT_WIDTH-1:0];
                        carrier_next = carrier_done ? '0 : carrier_inc[CARRIER_COUNT_WIDTH-1:0];
                    end
                end else begin
                    pre_next = pre_inc[TPU_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_reg     <= '0;
            frame_reg   <= '0;
            carrier_reg <= '0;
            wrap_reg    <= 1'b0;
        end else begin
            pre_reg     <= pre_next;
            frame_reg   <= frame_next;
            carrier_reg <= carrier_next;
            wrap_reg    <= wrap_next;
        end
    end

    // frame count, carrier count and wrap flag, in that order
    assign cnt = {frame_reg, carrier_reg, wrap_reg};

    // a frame wrap leaves both counters at zero until the next beat
    `BPPG_ASSERT_IMPL(a_wrap_clears, wrap_reg, (frame_reg == '0) && (carrier_reg == '0))
    // without an accepted beat the counters hold
    `BPPG_ASSERT_NEXT(a_hold_idle, !step, $stable(frame_reg) && $stable(carrier_reg))

endmodule

@@ rtl/core/bppg_decode.sv @@
// drive, dead time and trigger decode from the counter values
module bppg_decode import bppg_pkg::*; (
    input  cfg_t    cfg,
    input  count_t  cnt,
    output result_t res
);

    logic [FRAME_CMP_W-1:0]   fx, tstart, tend;
    logic [CARRIER_CMP_W-1:0] s, dead, half, half_dead;
    logic                     in_burst, lt_dead, lt_half, lt_half_dead;

    always_comb begin
        // burst window and carrier phase
        fx        = FRAME_CMP_W'(cnt.frame_microseconds);
        s         = CARRIER_CMP_W'(cnt.carrier_microseconds);
        dead      = CARRIER_CMP_W'(cfg.dead_time);
        half      = CARRIER_CMP_W'(cfg.half_point);
        half_dead = half + dead;
        in_burst     = fx < FRAME_CMP_W'(cfg.burst_length);
        lt_dead      = s < dead;
        lt_half      = s < half;
        lt_half_dead = s < half_dead;
        res.drive_a  = in_burst && !lt_dead && lt_half;
        res.drive_b  = in_burst && !lt_dead && !lt_half && !lt_half_dead;

        // trigger interval, end formed with a carry bit
        tstart = FRAME_CMP_W'(cfg.trigger_start);
        tend   = tstart + FRAME_CMP_W'(cfg.trigger_length);
        res.trigger_pulse = (fx >= tstart) && (fx < tend);
        res.frame_wrap    = cnt.frame_wrap;
    end

endmodule

@@ rtl/core/burst_pushpull_dead_time_gen.sv @@
// Complementary push-pull drive generator with dead time, burst window and trigger.
// Every input beat is one clock tick (tdata bit 0 = tick; 0 holds all counters) and
// yields exactly one result beat. One beat is accepted per cycle at full rate: the
// counters update on the accepting edge, their decode is loaded into the output
// register once that register is free, and back-pressure on the master side stalls
// the slave side only once both the counter stage and the output register are full.
// Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user must write
// it only while the block is idle (not enforced); indexes 8 and up are ignored.
module burst_pushpull_dead_time_gen import bppg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] tick, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] drive_a, [1] drive_b,
                                             // [2] trigger_pulse, [3] frame_wrap, [7:4] zero
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    `include "burst_pushpull_dead_time_gen_macros.svh"

    cfg_t    cfg;
    count_t  cnt;
    result_t res;
    result_t res_reg;

    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s1_adv, accept;

    bppg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bppg_timebase u_timebase (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .tick    (s_tdata[0]),
        .cfg     (cfg),
        .cnt     (cnt)
    );

    bppg_decode u_decode (
        .cfg (cfg),
        .cnt (cnt),
        .res (res)
    );

    // beat flow through counter stage and output register
    always_comb begin
        s1_adv        = !m_valid_reg || m_tready;
        s_tready      = !s1_valid_reg || s1_adv;
        accept        = s_tvalid && s_tready;
        s1_valid_next = accept || (s1_valid_reg && !s1_adv);
        m_valid_next  = s1_adv ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.frame_wrap, res_reg.trigger_pulse,
                       res_reg.drive_b, res_reg.drive_a};

    // the two drives are never high together
    `BPPG_ASSERT_IMPL(a_no_overlap, m_valid_reg, !(res_reg.drive_a && res_reg.drive_b))
    // a counted beat moves into an empty output register
    `BPPG_ASSERT_NEXT(a_stage_moves, s1_valid_reg && !m_valid_reg, m_valid_reg)

endmodule

@@ tb/burst_pushpull_dead_time_gen_test.sv @@
// self-checking testbench of the burst push-pull dead-time generator
module burst_pushpull_dead_time_gen_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bppg_pkg::*;

    localparam int LIMIT_CYCLES     = 200000;
    localparam int RANDOM_PHASES    = 10;
    localparam int BEATS_PER_PHASE  = 75;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PRESSURE_PHASE   = 4;
    localparam int DIRECTED_ROWS    = 46;
    // indexes 8 to 15 hold no register
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 4'd15;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  tick;
        logic                  known;
        result_t               result;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  cfg_wen;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predictor state: registers and the three counters
    cfg_t                           timing_regs;
    logic [TPU_W-1:0]               prescale_ticks;
    logic [FRAME_COUNT_WIDTH-1:0]   frame_us;
    logic [CARRIER_COUNT_WIDTH-1:0] carrier_us;

    result_t    expected_outputs[$];
    idle_mode_t idle_mode = IDLE_NONE;
    bit         long_hold_pending = 1'b0;
    int         mismatch_count = 0;
    int         result_beats = 0;
    int         cycles;

    burst_pushpull_dead_time_gen uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // one accepted beat of the timebase: counters first, then decode of the new counts
    function automatic result_t advance_timebase(input logic tick);
        int      next_pre;
        int      next_frame;
        int      next_carrier;
        int      count;
        int      dead;
        int      half;
        int      trig_from;
        result_t outs;
        outs = '0;
        if (tick) begin
            next_pre = int'(prescale_ticks) + 1;
            if (next_pre >= int'(timing_regs.ticks_per_microsecond) || next_pre >= (1 << TPU_W)) begin
                prescale_ticks = '0;
                next_frame = int'(frame_us) + 1;
                if (next_frame >= int'(timing_regs.frame_period) ||
                    next_frame >= (1 << FRAME_COUNT_WIDTH)) begin
                    // frame wrap also restarts the carrier
                    frame_us = '0;
                    carrier_us = '0;
                    outs.frame_wrap = 1'b1;
                end else begin
                    frame_us = FRAME_COUNT_WIDTH'(next_frame);
                    next_carrier = int'(carrier_us) + 1;
                    if (next_carrier >= int'(timing_regs.carrier_period) ||
                        next_carrier >= (1 << CARRIER_COUNT_WIDTH))
                        carrier_us = '0;
                    else
                        carrier_us = CARRIER_COUNT_WIDTH'(next_carrier);
                end
            end else begin
                prescale_ticks = TPU_W'(next_pre);
            end
        end
        // dead time, drive a, dead time, drive b inside the burst window
        if (int'(frame_us) < int'(timing_regs.burst_length)) begin
            count = int'(carrier_us);
            dead = int'(timing_regs.dead_time);
            half = int'(timing_regs.half_point);
            if (count >= dead && count < half)
                outs.drive_a = 1'b1;
            else if (count >= half + dead)
                outs.drive_b = 1'b1;
        end
        // trigger interval end formed without wrap
        trig_from = int'(timing_regs.trigger_start);
        outs.trigger_pulse = (int'(frame_us) >= trig_from) &&
                             (int'(frame_us) < trig_from + int'(timing_regs.trigger_length));
        return outs;
    endfunction

    function automatic int idle_percent(input idle_mode_t side);
        if (idle_mode == IDLE_BOTH)
            return 16;
        return (idle_mode == side) ? 71 : 0;
    endfunction

    // value with random junk above the register width now and then
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
            data = data | CFG_DATA_W'($urandom << width);
        return data;
    endfunction

    // register write, mirrored into the predictor
    task automatic write_timing_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (cfg_addr_t'(addr))
            REG_TPU:     timing_regs.ticks_per_microsecond = data[TPU_W-1:0];
            REG_FPERIOD: timing_regs.frame_period = data[FPERIOD_W-1:0];
            REG_BURST:   timing_regs.burst_length = data[BURST_W-1:0];
            REG_CPERIOD: timing_regs.carrier_period = data[CPERIOD_W-1:0];
            REG_HALF:    timing_regs.half_point = data[HALF_W-1:0];
            REG_DEAD:    timing_regs.dead_time = data[DEAD_W-1:0];
            REG_TSTART:  timing_regs.trigger_start = data[TSTART_W-1:0];
            REG_TLEN:    timing_regs.trigger_length = data[TLEN_W-1:0];
            default: ;
        endcase
    endtask

    // offer one tick beat, queue what it should produce once accepted
    task automatic send_beat(input logic tick, input logic known, input result_t typed);
        result_t predicted;
        while ($urandom_range(0, 99) < idle_percent(IDLE_SENDER)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, tick};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = advance_timebase(tick);
        expected_outputs.push_back(known ? typed : predicted);
    endtask

    // stop offering and let every expected beat come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge aclk);
    endtask

    // fresh random timing, extremes now and then
    task automatic pick_timing();
        int tpu;
        int fperiod;
        int burst;
        int cperiod;
        int half;
        int dead;
        int tstart;
        int tlen;
        case ($urandom_range(0, 9))
            0: tpu = 0;
            1: tpu = (1 << TPU_W) - 1;
            default: tpu = $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 9))
            0: fperiod = $urandom_range(0, 1);
            1: fperiod = (1 << FPERIOD_W) - 1;
            default: fperiod = $urandom_range(2, 60);
        endcase
        case ($urandom_range(0, 9))
            0: burst = 0;
            1: burst = (1 << BURST_W) - 1;
            default: burst = $urandom_range(0, 64);
        endcase
        case ($urandom_range(0, 9))
            0: cperiod = $urandom_range(0, 1);
            1: cperiod = (1 << CPERIOD_W) - 1;
            default: cperiod = $urandom_range(2, 20);
        endcase
        case ($urandom_range(0, 9))
            0: half = 0;
            1: half = (1 << HALF_W) - 1;
            default: half = $urandom_range(0, 22);
        endcase
        case ($urandom_range(0, 9))
            1: dead = (1 << DEAD_W) - 1;
            default: dead = $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 9))
            1: tstart = (1 << TSTART_W) - 1;
            default: tstart = $urandom_range(0, 60);
        endcase
        case ($urandom_range(0, 9))
            0: tlen = 0;
            1: tlen = (1 << TLEN_W) - 1;
            default: tlen = $urandom_range(0, 40);
        endcase
        write_timing_reg(REG_TPU, with_junk(tpu, TPU_W));
        write_timing_reg(REG_FPERIOD, with_junk(fperiod, FPERIOD_W));
        write_timing_reg(REG_BURST, with_junk(burst, BURST_W));
        write_timing_reg(REG_CPERIOD, with_junk(cperiod, CPERIOD_W));
        write_timing_reg(REG_HALF, with_junk(half, HALF_W));
        write_timing_reg(REG_DEAD, with_junk(dead, DEAD_W));
        write_timing_reg(REG_TSTART, with_junk(tstart, TSTART_W));
        write_timing_reg(REG_TLEN, with_junk(tlen, TLEN_W));
        // write to an index with no register behind it
        if ($urandom_range(0, 2) == 0)
            write_timing_reg(SPARE_ADDR - CFG_ADDR_W'($urandom_range(0, 7)),
                             CFG_DATA_W'($urandom));
    endtask

    // result side: check each beat, then pick the next tready
    initial begin
        result_t got;
        result_t want;
        int      hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = result_t'(m_tdata[3:0]);
                result_beats++;
                if (expected_outputs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat %0d: unexpected result, tdata=%b", result_beats, m_tdata);
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.drive_a !== want.drive_a || got.drive_b !== want.drive_b ||
                        got.trigger_pulse !== want.trigger_pulse ||
                        got.frame_wrap !== want.frame_wrap || m_tdata[7:4] !== 4'd0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("beat %0d: expected a=%b b=%b trig=%b wrap=%b, got tdata=%b",
                                     result_beats, want.drive_a, want.drive_b,
                                     want.trigger_pulse, want.frame_wrap, m_tdata);
                    end
                end
            end
            // long hold-off so the block fills and stalls its input
            if (long_hold_pending) begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !($urandom_range(0, 99) < idle_percent(IDLE_RECEIVER));
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("burst_pushpull_dead_time_gen: mismatch");
        $finish;
    end

    // stimulus
    initial begin
        plan_row_t plan [DIRECTED_ROWS];
        logic      after_beat;
        int        phase;
        int        n;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_wen <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        aresetn <= 1'b0;
        timing_regs = '{RST_TPU, RST_FPERIOD, RST_BURST, RST_CPERIOD,
                        RST_HALF, RST_DEAD, RST_TSTART, RST_TLEN};
        prescale_ticks = '0;
        frame_us = '0;
        carrier_us = '0;

        // result column reads {wrap, trigger, b, a}
        plan = '{
            // after reset: idle step, then a tick still inside the prescaler
            '{ROW_BEAT,  '0,          '0,         1'b0, 1'b1, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b0000},
            // zero divide ratio through masked upper bits, short frame and carrier
            '{ROW_WRITE, REG_TPU,     20'hABC00,  1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_FPERIOD, 20'd5,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_CPERIOD, 20'd3,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_HALF,    20'd2,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_DEAD,    20'd1,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_BURST,   20'hFFFFF,  1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_TSTART,  20'd3,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_TLEN,    20'hFFFFF,  1'b0, 1'b0, 4'b0000},
            // through a frame wrap that restarts the carrier mid-cycle
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b0, 1'b0, 4'b0000},
            // frame period one below a running count, carrier period zero
            '{ROW_WRITE, REG_FPERIOD, 20'd1,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_CPERIOD, 20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_DEAD,    20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_HALF,    20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b1010},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b1010},
            // frame period zero, empty then one-wide trigger at frame start
            '{ROW_WRITE, REG_FPERIOD, 20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_TSTART,  20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_TLEN,    20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b1010},
            '{ROW_WRITE, REG_TLEN,    20'd1,      1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b1110},
            // odd phases: dead time past half point and past the carrier end
            '{ROW_WRITE, REG_FPERIOD, 20'hFFFFF,  1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_CPERIOD, 20'd8,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_HALF,    20'd4,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_DEAD,    20'd6,      1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b0, 4'b0000},
            // slowest prescaler, closed window, trigger start at its top
            '{ROW_WRITE, REG_TPU,     20'd255,    1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_BURST,   20'd0,      1'b0, 1'b0, 4'b0000},
            '{ROW_WRITE, REG_TSTART,  20'hFFFFF,  1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b0000},
            // write to an index with no register
            '{ROW_WRITE, SPARE_ADDR,  20'hFFFFF,  1'b0, 1'b0, 4'b0000},
            '{ROW_BEAT,  '0,          '0,         1'b1, 1'b1, 4'b0000}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows, registers only written once everything has come out
        after_beat = 1'b0;
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            if (plan[n].kind == ROW_WRITE) begin
                if (after_beat)
                    drain_results();
                write_timing_reg(plan[n].addr, plan[n].data);
                after_beat = 1'b0;
            end else begin
                send_beat(plan[n].tick, plan[n].known, plan[n].result);
                after_beat = 1'b1;
            end
        end

        // random phases, each with its own timing and idling pattern
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            pick_timing();
            idle_mode = idle_mode_t'(phase % 4);
            if (phase == PRESSURE_PHASE)
                long_hold_pending = 1'b1;
            for (n = 0; n < BEATS_PER_PHASE; n++)
                send_beat($urandom_range(0, 99) < 85, 1'b0, '0);
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("burst_pushpull_dead_time_gen: match");
        else
            $display("burst_pushpull_dead_time_gen: mismatch");
        $finish;
    end

endmodule
